### rtl/core/assert_macros.svh
// assertion macros shared by the rtl core
// depends on nothing; users provide clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pda_pkg.sv
// types, constants and the arctangent table of the point direction unit
// no dependencies
package pda_pkg;

  // cordic vector width: magnitude stays below 2^61 for any coordinate width up to 59 bits
  localparam int VEC_W     = 64;
  // position of the binary point: coordinate bits plus guard bits
  localparam int GUARD_TOP = 59;
  // angle accumulator in millidegrees with 12 fraction bits
  localparam int Z_W       = 30;
  localparam int FRAC_BITS = 12;
  localparam int DIR_W     = 20;
  localparam int OUT_W     = 24;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [Z_W-1:0]   z_t;
  typedef logic signed [DIR_W-1:0] dir_t;

  localparam dir_t ANGLE_MAX  = dir_t'(89999);
  localparam dir_t ANGLE_MIN  = dir_t'(-89999);
  localparam dir_t DIR_DOWN   = dir_t'(270000);
  localparam dir_t DIR_UP     = dir_t'(90000);
  localparam dir_t DIR_LEFT   = dir_t'(180000);
  localparam dir_t DIR_LOWEST = dir_t'(-90000);
  localparam z_t   TRUNC_BIAS = z_t'((1 << FRAC_BITS) - 1);

  typedef struct packed {
    logic dx_zero;
    logic dx_neg;
    logic dy_pos;
  } pda_flags_t;

  // atan(2^-i) in millidegrees, 12 fraction bits, rounded to nearest
  function automatic z_t atan_entry(input int unsigned idx);
    z_t v;
    case (idx)
      0:       v = z_t'(184320000);
      1:       v = z_t'(108810450);
      2:       v = z_t'(57492453);
      3:       v = z_t'(29184067);
      4:       v = z_t'(14648666);
      5:       v = z_t'(7331474);
      6:       v = z_t'(3666632);
      7:       v = z_t'(1833428);
      8:       v = z_t'(916728);
      9:       v = z_t'(458366);
      10:      v = z_t'(229183);
      11:      v = z_t'(114592);
      12:      v = z_t'(57296);
      13:      v = z_t'(28648);
      14:      v = z_t'(14324);
      15:      v = z_t'(7162);
      16:      v = z_t'(3581);
      17:      v = z_t'(1790);
      18:      v = z_t'(895);
      19:      v = z_t'(448);
      20:      v = z_t'(224);
      21:      v = z_t'(112);
      22:      v = z_t'(56);
      23:      v = z_t'(28);
      24:      v = z_t'(14);
      25:      v = z_t'(7);
      26:      v = z_t'(3);
      27:      v = z_t'(2);
      28:      v = z_t'(1);
      default: v = z_t'(0);
    endcase
    return v;
  endfunction

endpackage

### rtl/core/pda_stage.sv
// one registered cordic micro-rotation in vectoring mode
// depends on pda_pkg and assert_macros.svh
`include "assert_macros.svh"

module pda_stage #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pda_pkg::vec_t       in_x,
  input  pda_pkg::vec_t       in_y,
  input  pda_pkg::z_t         in_z,
  input  pda_pkg::pda_flags_t in_flags,
  output logic                valid,
  input  logic                out_ready,
  output pda_pkg::vec_t       x,
  output pda_pkg::vec_t       y,
  output pda_pkg::z_t         z,
  output pda_pkg::pda_flags_t flags
);

  localparam pda_pkg::z_t Step = pda_pkg::atan_entry(SHIFT);

  pda_pkg::vec_t xs;
  pda_pkg::vec_t ys;
  pda_pkg::vec_t x_next;
  pda_pkg::vec_t y_next;
  pda_pkg::z_t   z_next;

  assign in_ready = ~valid | out_ready;

  always_comb begin
    xs = in_x >>> SHIFT;
    ys = in_y >>> SHIFT;
    // rotate towards the x axis
    if (!in_y[pda_pkg::VEC_W-1]) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + Step;
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - Step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x     <= x_next;
      y     <= y_next;
      z     <= z_next;
      flags <= in_flags;
    end
  end

  `ASSERT_ALWAYS(a_x_nonneg, !(valid && x[pda_pkg::VEC_W-1]), "cordic x went negative")

endmodule

### rtl/core/point_direction_angle_unit.sv
// top level of the point direction unit: prep stage, cordic pipeline, output stages
// depends on pda_pkg, pda_stage and assert_macros.svh
//
// usage
//   slave channel s_*: one word per point pair, master channel m_*: one word
//   per direction, in the same order as the pairs arrive
//   direction is in millidegrees with the y axis pointing down, -89999..270000
//   a word passes from acceptance to m_tvalid through the prep stage, one
//   stage per cordic iteration, the truncation stage and the output
//   register; throughput is one word per cycle while m_tready stays high,
//   set by the unrolled cordic with one micro-rotation per register stage
//   every stage carries its own valid bit and takes a new word when empty or
//   when its successor takes its word, so a stalled receiver lets bubbles
//   close up and s_tready only falls once every stage holds a word
//   nothing is lost or repeated while m_tready is low
//   reset clears all valid bits; the pipeline is empty and ready afterwards
//   a vertical pair (dx of zero) bypasses the angle and gives 270000 when
//   dy is positive and 90000 otherwise
`include "assert_macros.svh"

module point_direction_angle_unit #(
  parameter  int COORD_BITS = 24,
  parameter  int ITERATIONS = 24,
  localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // start_x, start_y, end_x, end_y, each COORD_BITS, zero padded to bytes
  input  logic [IN_W-1:0]           s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // direction (20 bits signed), zero padded to 24 bits
  output logic [pda_pkg::OUT_W-1:0] m_tdata
);

  // coordinate scaling so the binary point sits at a fixed place
  localparam int GUARD_BITS = pda_pkg::GUARD_TOP - COORD_BITS;
  localparam int EXT_BITS   = pda_pkg::VEC_W - COORD_BITS - 1;

  // input fields
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  // exact differences, one bit wider than a coordinate
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] dx_abs;
  logic signed [COORD_BITS:0] yv;
  pda_pkg::vec_t              x_init;
  pda_pkg::vec_t              y_init;
  pda_pkg::pda_flags_t        flags_init;

  // prep register
  logic                prep_valid;
  pda_pkg::vec_t       prep_x;
  pda_pkg::vec_t       prep_y;
  pda_pkg::pda_flags_t prep_flags;

  // slot k is the word after k micro-rotations; slot 0 is the prep register
  logic [ITERATIONS:0]  c_valid;
  logic [ITERATIONS:0]  c_ready;
  pda_pkg::vec_t        c_x     [0:ITERATIONS];
  pda_pkg::vec_t        c_y     [0:ITERATIONS];
  pda_pkg::z_t          c_z     [0:ITERATIONS];
  pda_pkg::pda_flags_t  c_flags [0:ITERATIONS];

  // truncation stage
  logic                t1_valid;
  logic                t2_ready;
  pda_pkg::dir_t       a_sat;
  pda_pkg::dir_t       a_sat_next;
  pda_pkg::pda_flags_t t1_flags;
  pda_pkg::z_t         z_adj;
  pda_pkg::z_t         a_full;

  // output register
  pda_pkg::dir_t direction;
  pda_pkg::dir_t direction_next;

  assign start_x = s_tdata[0*COORD_BITS +: COORD_BITS];
  assign start_y = s_tdata[1*COORD_BITS +: COORD_BITS];
  assign end_x   = s_tdata[2*COORD_BITS +: COORD_BITS];
  assign end_y   = s_tdata[3*COORD_BITS +: COORD_BITS];

  // prep: differences, fold into the right half plane, scale up
  always_comb begin
    dx     = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy     = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    dx_abs = dx[COORD_BITS] ? -dx : dx;
    yv     = (!dx[COORD_BITS] && (dx != '0)) ? dy : -dy;
    x_init = pda_pkg::vec_t'({{EXT_BITS{dx_abs[COORD_BITS]}}, dx_abs}) <<< GUARD_BITS;
    y_init = pda_pkg::vec_t'({{EXT_BITS{yv[COORD_BITS]}}, yv}) <<< GUARD_BITS;
    flags_init.dx_zero = (dx == '0);
    flags_init.dx_neg  = dx[COORD_BITS];
    flags_init.dy_pos  = !dy[COORD_BITS] && (dy != '0);
  end

  assign s_tready = ~prep_valid | c_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (s_tready) begin
      prep_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      prep_x     <= x_init;
      prep_y     <= y_init;
      prep_flags <= flags_init;
    end
  end

  // the accumulator starts from zero
  assign c_valid[0] = prep_valid;
  assign c_x[0]     = prep_x;
  assign c_y[0]     = prep_y;
  assign c_z[0]     = '0;
  assign c_flags[0] = prep_flags;

  // unrolled cordic, one micro-rotation per register stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    pda_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (c_valid[i]),
      .in_ready (c_ready[i]),
      .in_x     (c_x[i]),
      .in_y     (c_y[i]),
      .in_z     (c_z[i]),
      .in_flags (c_flags[i]),
      .valid    (c_valid[i+1]),
      .out_ready(c_ready[i+1]),
      .x        (c_x[i+1]),
      .y        (c_y[i+1]),
      .z        (c_z[i+1]),
      .flags    (c_flags[i+1])
    );
  end

  // truncate the accumulator towards zero and clamp to the open quadrant
  assign c_ready[ITERATIONS] = ~t1_valid | t2_ready;

  always_comb begin
    z_adj  = c_z[ITERATIONS] + (c_z[ITERATIONS][pda_pkg::Z_W-1] ? pda_pkg::TRUNC_BIAS : '0);
    a_full = z_adj >>> pda_pkg::FRAC_BITS;
    if (a_full > pda_pkg::z_t'(pda_pkg::ANGLE_MAX)) begin
      a_sat_next = pda_pkg::ANGLE_MAX;
    end else if (a_full < pda_pkg::z_t'(pda_pkg::ANGLE_MIN)) begin
      a_sat_next = pda_pkg::ANGLE_MIN;
    end else begin
      a_sat_next = a_full[pda_pkg::DIR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else if (c_ready[ITERATIONS]) begin
      t1_valid <= c_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready[ITERATIONS] && c_valid[ITERATIONS]) begin
      a_sat    <= a_sat_next;
      t1_flags <= c_flags[ITERATIONS];
    end
  end

  // map the angle to the screen quadrants
  assign t2_ready = ~m_tvalid | m_tready;

  always_comb begin
    if (t1_flags.dx_zero) begin
      direction_next = t1_flags.dy_pos ? pda_pkg::DIR_DOWN : pda_pkg::DIR_UP;
    end else if (t1_flags.dx_neg) begin
      direction_next = pda_pkg::DIR_LEFT - a_sat;
    end else begin
      direction_next = -a_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (t2_ready) begin
      m_tvalid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (t2_ready && t1_valid) begin
      direction <= direction_next;
    end
  end

  assign m_tdata = {{(pda_pkg::OUT_W - pda_pkg::DIR_W){1'b0}}, direction};

  `ASSERT_IMPL(a_dir_range, m_tvalid, (direction >= pda_pkg::DIR_LOWEST) && (direction <= pda_pkg::DIR_DOWN), "direction out of range")
  `ASSERT_IMPL(a_empty_out_ready, !m_tvalid, s_tready, "input stalled with empty output")
  `ASSERT_IMPL(a_angle_clamped, t1_valid, (a_sat <= pda_pkg::ANGLE_MAX) && (a_sat >= pda_pkg::ANGLE_MIN), "angle not clamped")
  `ASSERT_NEXT(a_vertical, t1_valid && t2_ready && t1_flags.dx_zero, (direction == pda_pkg::DIR_DOWN) || (direction == pda_pkg::DIR_UP), "vertical pair gave a slanted direction")

endmodule

### verif/pda_direction_checker.sv
// checker for the point direction unit: watches both stream channels, predicts each direction
// word with a bit-true fixed-point cordic and compares it with what the unit sends
// depends on pda_pkg
module pda_direction_checker #(
  parameter int COORD_BITS = 24,
  parameter int ITERATIONS = 24,
  parameter int IN_W       = 96
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [IN_W-1:0]           s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  // direction, zero padding
  input  logic [pda_pkg::OUT_W-1:0] m_tdata,
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     GUARD       = 59 - COORD_BITS;
  localparam int     ACC_FRAC    = 12;
  localparam longint SAT_ANGLE   = 89999;
  localparam longint FACING_DOWN = 270000;
  localparam longint FACING_UP   = 90000;
  localparam longint FACING_LEFT = 180000;

  // atan(2^-i) in millidegrees with 12 fraction bits
  longint atan_mdeg [0:31] = '{
    184320000, 108810450, 57492453, 29184067, 14648666, 7331474,
    3666632, 1833428, 916728, 458366, 229183, 114592, 57296, 28648,
    14324, 7162, 3581, 1790, 895, 448, 224, 112, 56, 28, 14, 7, 3, 2,
    1, 0, 0, 0
  };

  pda_pkg::dir_t expected_dirs [$];
  pda_pkg::dir_t seen_dir;
  pda_pkg::dir_t due_dir;

  function automatic pda_pkg::dir_t direction_of(input logic [IN_W-1:0] word);
    longint coord [4];
    longint dx, dy, vx, vy, za, xs, ys, ang, res;
    for (int k = 0; k < 4; k++) begin
      coord[k] = longint'($signed(word[k*COORD_BITS +: COORD_BITS]));
    end
    dx = coord[2] - coord[0];
    dy = coord[3] - coord[1];
    if (dx == 0) begin
      res = (dy > 0) ? FACING_DOWN : FACING_UP;
    end else begin
      // fold into the right half plane, then rotate towards y = 0
      vx = ((dx > 0) ? dx : -dx) <<< GUARD;
      vy = ((dx > 0) ? dy : -dy) <<< GUARD;
      za = 0;
      for (int i = 0; i < ITERATIONS && i < 32; i++) begin
        xs = vx >>> i;
        ys = vy >>> i;
        if (vy >= 0) begin
          vx += ys;
          vy -= xs;
          za += atan_mdeg[i];
        end else begin
          vx -= ys;
          vy += xs;
          za -= atan_mdeg[i];
        end
      end
      ang = (za >= 0) ? (za >>> ACC_FRAC) : -((-za) >>> ACC_FRAC);
      if (ang > SAT_ANGLE) ang = SAT_ANGLE;
      if (ang < -SAT_ANGLE) ang = -SAT_ANGLE;
      res = (dx > 0) ? -ang : FACING_LEFT - ang;
    end
    return pda_pkg::dir_t'(res);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_dirs.push_back(direction_of(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        seen_dir = m_tdata[pda_pkg::DIR_W-1:0];
        if (expected_dirs.size() == 0) begin
          $error("direction: expected nothing, actual %0d", seen_dir);
          mismatches <= mismatches + 1;
        end else begin
          due_dir = expected_dirs.pop_front();
          if (due_dir != seen_dir) begin
            $error("direction: expected %0d, actual %0d", due_dir, seen_dir);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= expected_dirs.size();
    end
  end

endmodule

### verif/tb_point_direction_angle_unit.sv
// testbench top of the point direction unit: clock, reset, stimulus and verdict
// depends on pda_pkg, point_direction_angle_unit and pda_direction_checker
module tb_point_direction_angle_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 24;
  localparam int ITERATIONS = 24;
  localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8;
  // extremes of a coordinate
  localparam int C_MIN      = -(1 << (COORD_BITS - 1));
  localparam int C_MAX      = (1 << (COORD_BITS - 1)) - 1;
  // pipeline depth plus a margin for the drain at the end
  localparam int DRAIN      = ITERATIONS + 3 + 10;
  // cycles with no word moving on either side before the run is given up
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 150;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  // start_x, start_y, end_x, end_y from bit 0 up
  logic [IN_W-1:0]           s_tdata  = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  // direction (20 bits signed), then zero padding
  logic [pda_pkg::OUT_W-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int idle_pct  = 0;   // chance in a hundred that the sender rests between words
  int stall_pct = 0;   // chance in a hundred that the receiver holds off
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  point_direction_angle_unit #(
    .COORD_BITS(COORD_BITS),
    .ITERATIONS(ITERATIONS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  pda_direction_checker #(
    .COORD_BITS(COORD_BITS),
    .ITERATIONS(ITERATIONS),
    .IN_W      (IN_W)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: a correct unit moves a word on one side or the other well within the limit
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // packs one point pair into a word, start_x lowest
  function automatic logic [IN_W-1:0] pair_word(input int sx, input int sy,
                                                input int ex, input int ey);
    return {ey[COORD_BITS-1:0], ex[COORD_BITS-1:0], sy[COORD_BITS-1:0], sx[COORD_BITS-1:0]};
  endfunction

  // random point pair; most are shaped towards the interesting geometry
  function automatic logic [IN_W-1:0] random_pair();
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    int unsigned           shape;
    int unsigned           d;
    sx    = COORD_BITS'($urandom);
    sy    = COORD_BITS'($urandom);
    ex    = COORD_BITS'($urandom);
    ey    = COORD_BITS'($urandom);
    shape = $urandom_range(9);
    d     = $urandom_range(4095);
    case (shape)
      4, 5: begin
        // short segment, wrapping at the edges of the coordinate range
        ex = COORD_BITS'(sx + $urandom_range(511) - 256);
        ey = COORD_BITS'(sy + $urandom_range(511) - 256);
      end
      6: begin
        // vertical, sometimes a single point
        ex = sx;
        if ($urandom_range(3) == 0) ey = sy;
      end
      7: begin
        ey = sy;
      end
      8: begin
        // almost vertical, exercises the angle saturation
        ex = COORD_BITS'($urandom_range(1) ? sx + $urandom_range(2, 1)
                                           : sx - $urandom_range(2, 1));
      end
      9: begin
        // diagonal, angle on a multiple of 45 degrees unless an end wraps at the range edge
        ex = COORD_BITS'($urandom_range(1) ? sx + d : sx - d);
        ey = COORD_BITS'($urandom_range(1) ? sy + d : sy - d);
      end
      default: begin
      end
    endcase
    return IN_W'({ey, ex, sy, sx});
  endfunction

  // offers one word and waits for it to be taken, then maybe rests
  task automatic push_pair(input logic [IN_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words, no idling on either side
    push_pair(pair_word(0, 0, 0, 0));                      // single point at the origin
    push_pair(pair_word(1234, -777, 1234, -777));          // single point elsewhere
    push_pair(pair_word(C_MAX, C_MAX, C_MAX, C_MAX));      // all fields at the top
    push_pair(pair_word(C_MIN, C_MIN, C_MIN, C_MIN));      // all fields at the bottom
    push_pair(pair_word(0, 0, 0, 5));                      // straight down
    push_pair(pair_word(0, 5, 0, 0));                      // straight up
    push_pair(pair_word(C_MIN, C_MIN, C_MIN, C_MAX));      // full-height vertical, down
    push_pair(pair_word(C_MAX, C_MAX, C_MAX, C_MIN));      // full-height vertical, up
    push_pair(pair_word(0, 0, 7, 0));                      // due right
    push_pair(pair_word(7, 0, 0, 0));                      // due left
    push_pair(pair_word(C_MIN, 0, C_MAX, 0));              // widest horizontal
    push_pair(pair_word(C_MIN, C_MIN, C_MAX, C_MAX));      // widest diagonals, each quadrant
    push_pair(pair_word(C_MAX, C_MAX, C_MIN, C_MIN));
    push_pair(pair_word(C_MIN, C_MAX, C_MAX, C_MIN));
    push_pair(pair_word(C_MAX, C_MIN, C_MIN, C_MAX));
    push_pair(pair_word(0, C_MIN, 1, C_MAX));              // steepest slopes, angle saturates
    push_pair(pair_word(1, C_MIN, 0, C_MAX));
    push_pair(pair_word(0, C_MAX, 1, C_MIN));
    push_pair(pair_word(1, C_MAX, 0, C_MIN));
    push_pair(pair_word(0, 0, 1, 1));                      // smallest diagonal
    push_pair(pair_word(0, 0, 3, -4));

    // random words in idling phases: none, sender, receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 84; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 84; end
        default: begin idle_pct = 20; stall_pct <= 20; end
      endcase
      repeat (PHASE_WORDS) push_pair(random_pair());
    end
    s_tvalid <= 1'b0;

    // drain: every prediction answered, then a margin for stray words
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### point_direction_angle_unit.f
+incdir+rtl/core
rtl/core/pda_pkg.sv
rtl/core/pda_stage.sv
rtl/core/point_direction_angle_unit.sv
verif/pda_direction_checker.sv
verif/tb_point_direction_angle_unit.sv
